/* rtl/core/csh_pkg.sv */
// Shared types and codes for the curtain stepper homing controller.
package csh_pkg;

    typedef enum logic [6:0] {
        MODE_STOPPED   = 7'b0000001,
        MODE_CLOSED    = 7'b0000010,
        MODE_OPEN      = 7'b0000100,
        MODE_OPENING   = 7'b0001000,
        MODE_CLOSING   = 7'b0010000,
        MODE_CALIBRATE = 7'b0100000,
        MODE_PENDING   = 7'b1000000
    } mode_t;

    localparam logic [2:0] MS_STOPPED   = 3'd0;
    localparam logic [2:0] MS_CLOSED    = 3'd1;
    localparam logic [2:0] MS_OPEN      = 3'd2;
    localparam logic [2:0] MS_OPENING   = 3'd3;
    localparam logic [2:0] MS_CLOSING   = 3'd4;
    localparam logic [2:0] MS_CALIBRATE = 3'd5;
    localparam logic [2:0] MS_PENDING   = 3'd6;

    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_OPEN      = 3'd1;
    localparam logic [2:0] OP_CLOSE     = 3'd2;
    localparam logic [2:0] OP_STOP      = 3'd3;
    localparam logic [2:0] OP_CALIBRATE = 3'd4;
    localparam logic [2:0] OP_POWER_CHK = 3'd5;

    localparam logic CFG_MAX_STEPS = 1'b0;
    localparam logic CFG_CLOSE_DIR = 1'b1;

    localparam int MAX_STEPS_W = 23;
    localparam logic [MAX_STEPS_W-1:0] MAX_STEPS_RST = 23'd10000;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        case (m)
            MODE_STOPPED:   c = MS_STOPPED;
            MODE_CLOSED:    c = MS_CLOSED;
            MODE_OPEN:      c = MS_OPEN;
            MODE_OPENING:   c = MS_OPENING;
            MODE_CLOSING:   c = MS_CLOSING;
            MODE_CALIBRATE: c = MS_CALIBRATE;
            default:        c = MS_PENDING;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/curtain_stepper_homing_fsm.sv */
// Curtain stepper homing controller: mode machine, step issue and position tracking.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | operation, switch_closed, pulse_busy
//  m_      | out       | m_tvalid/m_tready  | motor_state, enable, dir, step_fire, position
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while s_tready is high; the result is in the output register in the cycle after acceptance.
// The whole control step is one combinational pass from the state registers.
// aresetn (synchronous, active low) returns all modes, flags and config to defaults.
// s_tready drops only while a result is held and m_tready is low; cfg_ready is always high.
module curtain_stepper_homing_fsm
    import csh_pkg::*;
#(
    parameter int STEP_INC        = 1,
    parameter int SOFT_STOP_LIMIT = 500,
    parameter int POS_WIDTH       = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] operation, [3] switch_closed, [4] pulse_busy
    input  logic [7:0]             s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [2:0] motor_state, [3] enable_level, [4] dir_level, [5] step_fire, [..:6] position
    output logic [((6 + POS_WIDTH + 7) / 8) * 8-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [MAX_STEPS_W-1:0] cfg_data
);

    localparam int OUT_W = ((6 + POS_WIDTH + 7) / 8) * 8;
    localparam int CW = ((POS_WIDTH > 24) ? POS_WIDTH : 24) + 2;
    localparam logic signed [CW-1:0] POS_HI = CW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] POS_LO = -POS_HI - CW'(1);
    localparam logic signed [CW-1:0] SOFT_NEG = -CW'(SOFT_STOP_LIMIT);
    localparam logic signed [CW-1:0] INC = CW'(STEP_INC);

    logic [MAX_STEPS_W-1:0] max_steps_reg;
    logic                   close_dir_reg;

    mode_t                  cur_reg, cur_next;
    mode_t                  tgt_reg, tgt_next;
    logic [POS_WIDTH-1:0]   pos_reg, pos_next;
    logic                   home_reg, home_next;
    logic                   oah_reg, oah_next;
    logic                   enable_reg, enable_next;
    logic                   dir_reg, dir_next;
    logic                   fire_next;

    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;

    logic [2:0]             op;
    logic                   sw;
    logic                   busy;
    logic                   in_acc;

    assign op   = s_tdata[2:0];
    assign sw   = s_tdata[3];
    assign busy = s_tdata[4];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        logic                 toward;
        logic signed [CW-1:0] pos_ext;
        logic signed [CW-1:0] sum;
        logic signed [CW-1:0] sat;

        cur_next    = cur_reg;
        tgt_next    = tgt_reg;
        pos_next    = pos_reg;
        home_next   = home_reg;
        oah_next    = oah_reg;
        enable_next = enable_reg;
        dir_next    = dir_reg;
        fire_next   = 1'b0;

        case (op)
            OP_OPEN:      tgt_next = MODE_OPENING;
            OP_CLOSE:     tgt_next = MODE_CLOSING;
            OP_STOP:      tgt_next = MODE_STOPPED;
            OP_CALIBRATE: tgt_next = MODE_CALIBRATE;
            OP_POWER_CHK: begin
                enable_next = 1'b1;
                if (!sw) begin
                    tgt_next = MODE_CALIBRATE;
                end else begin
                    home_next = 1'b1;
                end
            end
            default: ;
        endcase

        if (home_next) begin
            pos_next    = '0;
            home_next   = 1'b0;
            cur_next    = MODE_CLOSED;
            tgt_next    = MODE_CLOSED;
            enable_next = 1'b1;
            if (oah_next) begin
                tgt_next = MODE_OPENING;
                oah_next = 1'b0;
            end
        end

        if (((cur_next == MODE_CLOSING || cur_next == MODE_CLOSED || cur_next == MODE_STOPPED)
                && tgt_next == MODE_OPENING) ||
            ((cur_next == MODE_OPENING || cur_next == MODE_OPEN || cur_next == MODE_STOPPED)
                && tgt_next == MODE_CLOSING) ||
            tgt_next == MODE_CALIBRATE) begin
            if (tgt_next == MODE_OPENING && !sw) begin
                oah_next = 1'b1;
                cur_next = MODE_CALIBRATE;
            end else begin
                cur_next = tgt_next;
            end
            tgt_next    = MODE_PENDING;
            enable_next = 1'b0;
        end else if ((cur_next == MODE_OPENING && tgt_next == MODE_OPEN) ||
                     (cur_next == MODE_CLOSING && tgt_next == MODE_CLOSED) ||
                     tgt_next == MODE_STOPPED) begin
            cur_next    = tgt_next;
            tgt_next    = MODE_PENDING;
            enable_next = 1'b1;
        end

        toward  = (cur_next == MODE_CLOSING) || (cur_next == MODE_CALIBRATE);
        pos_ext = CW'($signed(pos_next));
        sum     = toward ? (pos_ext - INC) : (pos_ext + INC);
        if (sum > POS_HI) begin
            sat = POS_HI;
        end else if (sum < POS_LO) begin
            sat = POS_LO;
        end else begin
            sat = sum;
        end

        if ((toward || cur_next == MODE_OPENING) && !busy) begin
            dir_next = toward ? close_dir_reg : !close_dir_reg;
            if (sw && toward) begin
                home_next = 1'b1;
            end else begin
                fire_next = 1'b1;
                pos_next  = sat[POS_WIDTH-1:0];
                if (sat >= $signed({{(CW - MAX_STEPS_W){1'b0}}, max_steps_reg})) begin
                    tgt_next = MODE_OPEN;
                end
                if (sat < SOFT_NEG && cur_next != MODE_CALIBRATE) begin
                    home_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_steps_reg <= MAX_STEPS_RST;
            close_dir_reg <= 1'b0;
            cur_reg       <= MODE_STOPPED;
            tgt_reg       <= MODE_STOPPED;
            pos_reg       <= '0;
            home_reg      <= 1'b0;
            oah_reg       <= 1'b0;
            enable_reg    <= 1'b1;
            dir_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MAX_STEPS: max_steps_reg <= cfg_data;
                    CFG_CLOSE_DIR: close_dir_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                cur_reg    <= cur_next;
                tgt_reg    <= tgt_next;
                pos_reg    <= pos_next;
                home_reg   <= home_next;
                oah_reg    <= oah_next;
                enable_reg <= enable_next;
                dir_reg    <= dir_next;
            end
            if (in_acc) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            m_tdata_reg <= OUT_W'({pos_next, fire_next, dir_next, enable_next,
                                   mode_code(cur_next)});
        end
    end

endmodule

/* rtl/core/csh_checker.sv */
// Port-level checker for the curtain stepper homing controller, bound to the top level.
module csh_checker
    import csh_pkg::*;
#(
    parameter int POS_WIDTH = 24
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((6 + POS_WIDTH + 7) / 8) * 8-1:0] m_tdata
);

    logic [2:0] ms;
    logic       fire;
    logic       en;

    assign ms   = m_tdata[2:0];
    assign en   = m_tdata[3];
    assign fire = m_tdata[5];

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item gave no result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_fire_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && fire) |->
            ((ms == MS_OPENING || ms == MS_CLOSING || ms == MS_CALIBRATE) && !en))
        else $error("step fired outside a driven movement mode");

endmodule

bind curtain_stepper_homing_fsm csh_checker #(.POS_WIDTH(POS_WIDTH)) u_csh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* dv/testbench.sv */
// Self-checking testbench for the curtain stepper homing controller.
`timescale 1ns / 100ps

module testbench;
    import csh_pkg::*;

    localparam int STEP_INC        = 1;
    localparam int SOFT_STOP_LIMIT = 500;
    localparam int POS_WIDTH       = 24;
    localparam longint POS_MAX     = (64'sd1 <<< (POS_WIDTH - 1)) - 1;
    localparam longint POS_MIN     = -POS_MAX - 1;
    localparam int STALL_LIMIT     = 2000;
    localparam int PHASE_ITEMS     = 85;

    typedef struct packed {
        logic       busy;
        logic       sw;
        logic [2:0] op;
    } ctrl_tick_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] position;
        logic                        fire;
        logic                        dir;
        logic                        enable;
        logic [2:0]                  state;
    } motor_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // [2:0] operation, [3] switch_closed, [4] pulse_busy
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // [2:0] motor_state, [3] enable_level, [4] dir_level, [5] step_fire, [29:6] position
    logic [31:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = CFG_MAX_STEPS;
    logic [MAX_STEPS_W-1:0] cfg_data = '0;

    curtain_stepper_homing_fsm DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // predictor state
    logic [2:0]             cur_mode;
    logic [2:0]             tgt_mode;
    longint                 pos_count;
    bit                     home_hit;
    bit                     open_after_cal;
    bit                     enable_q;
    bit                     dir_q;
    logic [MAX_STEPS_W-1:0] open_limit;
    bit                     close_dir;

    ctrl_tick_t    pending_ticks[$];
    motor_report_t expected_reports[$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            s_gap_left = 0;
    int            m_stall_left = 0;
    bit            s_gappy = 1'b1;
    bit            m_gappy = 1'b1;
    bit            switch_lvl = 1'b0;

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic motor_report_t curtain_tick(input ctrl_tick_t t);
        motor_report_t rep;
        bit            toward_home;
        bit            fire;
        fire = 1'b0;
        case (t.op)
            OP_OPEN:      tgt_mode = MS_OPENING;
            OP_CLOSE:     tgt_mode = MS_CLOSING;
            OP_STOP:      tgt_mode = MS_STOPPED;
            OP_CALIBRATE: tgt_mode = MS_CALIBRATE;
            OP_POWER_CHK: begin
                enable_q = 1'b1;
                if (!t.sw) tgt_mode = MS_CALIBRATE;
                else home_hit = 1'b1;
            end
            default: ;
        endcase

        if (home_hit) begin
            pos_count = 0;
            home_hit = 1'b0;
            cur_mode = MS_CLOSED;
            tgt_mode = MS_CLOSED;
            enable_q = 1'b1;
            if (open_after_cal) begin
                tgt_mode = MS_OPENING;
                open_after_cal = 1'b0;
            end
        end

        if (((cur_mode == MS_CLOSING || cur_mode == MS_CLOSED || cur_mode == MS_STOPPED)
                && tgt_mode == MS_OPENING)
                || ((cur_mode == MS_OPENING || cur_mode == MS_OPEN || cur_mode == MS_STOPPED)
                && tgt_mode == MS_CLOSING)
                || tgt_mode == MS_CALIBRATE) begin
            if (tgt_mode == MS_OPENING && !t.sw) begin
                open_after_cal = 1'b1;
                cur_mode = MS_CALIBRATE;
            end else begin
                cur_mode = tgt_mode;
            end
            tgt_mode = MS_PENDING;
            enable_q = 1'b0;
        end else if ((cur_mode == MS_OPENING && tgt_mode == MS_OPEN)
                || (cur_mode == MS_CLOSING && tgt_mode == MS_CLOSED)
                || tgt_mode == MS_STOPPED) begin
            cur_mode = tgt_mode;
            tgt_mode = MS_PENDING;
            enable_q = 1'b1;
        end

        if ((cur_mode == MS_CLOSING || cur_mode == MS_CALIBRATE || cur_mode == MS_OPENING)
                && !t.busy) begin
            toward_home = (cur_mode == MS_CLOSING || cur_mode == MS_CALIBRATE);
            dir_q = toward_home ? close_dir : ~close_dir;
            if (t.sw && toward_home) begin
                home_hit = 1'b1;
            end else begin
                fire = 1'b1;
                pos_count = pos_count + (toward_home ? -STEP_INC : STEP_INC);
                if (pos_count > POS_MAX) pos_count = POS_MAX;
                if (pos_count < POS_MIN) pos_count = POS_MIN;
                if (pos_count >= longint'(open_limit)) tgt_mode = MS_OPEN;
                if (pos_count < -SOFT_STOP_LIMIT && cur_mode != MS_CALIBRATE) home_hit = 1'b1;
            end
        end

        rep.state    = cur_mode;
        rep.enable   = enable_q;
        rep.dir      = dir_q;
        rep.fire     = fire;
        rep.position = pos_count[POS_WIDTH-1:0];
        return rep;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_reports.push_back(curtain_tick(ctrl_tick_t'(s_tdata[4:0])));
            if (!s_tvalid || s_tready) begin
                if (s_gap_left > 0) begin
                    s_gap_left <= s_gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    s_tdata <= {3'b000, pending_ticks.pop_front()};
                    s_tvalid <= 1'b1;
                    s_gap_left <= s_gappy ? pick_idle() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        motor_report_t got;
        motor_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(motor_report_t)-1:0];
                if (expected_reports.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected report: state %0d pos %0d", got.state,
                                 got.position);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.state !== want.state || got.enable !== want.enable
                            || got.dir !== want.dir || got.fire !== want.fire
                            || got.position !== want.position) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"report mismatch (exp/got): state %0d/%0d en %0b/%0b ",
                                      "dir %0b/%0b step %0b/%0b pos %0d/%0d"},
                                     want.state, got.state, want.enable, got.enable,
                                     want.dir, got.dir, want.fire, got.fire,
                                     want.position, got.position);
                    end
                end
            end
            if (m_stall_left > 0) begin
                m_stall_left <= m_stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_gappy && $urandom_range(0, 3) == 0)
                    m_stall_left <= pick_idle();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_tick(input logic [2:0] op, input bit sw, input bit busy);
        ctrl_tick_t t;
        t.op = op;
        t.sw = sw;
        t.busy = busy;
        pending_ticks.push_back(t);
    endtask

    task automatic write_reg(input logic idx, input logic [MAX_STEPS_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_MAX_STEPS) open_limit = val;
        else close_dir = val[0];
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_ticks.size() > 0 || s_tvalid || expected_reports.size() > 0);
        repeat (4) @(negedge aclk);
    endtask

    // one command (sometimes an idle or unused code) followed by a run of mostly plain ticks; switch level mostly held
    task automatic queue_episode(inout int count);
        int          len;
        int          flip_at;
        logic [2:0]  op;
        len = $urandom_range(1, 25);
        op = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(OP_OPEN, OP_POWER_CHK))
                                          : 3'($urandom_range(0, 7));
        if ($urandom_range(0, 2) == 0) switch_lvl = ~switch_lvl;
        flip_at = ($urandom_range(0, 1) == 0) ? $urandom_range(0, len) : -1;
        push_tick(op, switch_lvl, $urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            if (i == flip_at) switch_lvl = ~switch_lvl;
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : OP_NONE;
            push_tick(op, switch_lvl, $urandom_range(0, 3) == 0);
        end
        count += len + 1;
    endtask

    initial begin
        int count;
        cur_mode = MS_STOPPED;
        tgt_mode = MS_STOPPED;
        pos_count = 0;
        home_hit = 1'b0;
        open_after_cal = 1'b0;
        enable_q = 1'b1;
        dir_q = 1'b0;
        open_limit = MAX_STEPS_RST;
        close_dir = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        push_tick(OP_NONE, 1'b0, 1'b0);
        push_tick(OP_POWER_CHK, 1'b0, 1'b0);
        push_tick(OP_NONE, 1'b0, 1'b1);
        push_tick(OP_NONE, 1'b1, 1'b0);
        push_tick(OP_NONE, 1'b1, 1'b0);
        push_tick(OP_OPEN, 1'b1, 1'b0);
        push_tick(OP_NONE, 1'b0, 1'b0);
        push_tick(OP_NONE, 1'b0, 1'b1);
        push_tick(OP_STOP, 1'b0, 1'b0);
        push_tick(OP_OPEN, 1'b0, 1'b0);
        push_tick(OP_NONE, 1'b0, 1'b0);
        push_tick(OP_NONE, 1'b1, 1'b0);
        push_tick(OP_NONE, 1'b1, 1'b0);
        push_tick(OP_NONE, 1'b1, 1'b0);
        push_tick(3'd6, 1'b0, 1'b0);
        push_tick(3'd7, 1'b1, 1'b1);
        push_tick(OP_CLOSE, 1'b0, 1'b0);
        push_tick(OP_NONE, 1'b0, 1'b0);
        push_tick(OP_CALIBRATE, 1'b0, 1'b1);
        push_tick(OP_POWER_CHK, 1'b1, 1'b0);
        push_tick(OP_CLOSE, 1'b1, 1'b0);
        push_tick(OP_CALIBRATE, 1'b1, 1'b0);
        push_tick(OP_NONE, 1'b0, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_MAX_STEPS, '0);
                    write_reg(CFG_CLOSE_DIR, 23'd1);
                end
                1: begin
                    write_reg(CFG_MAX_STEPS, '1);
                    write_reg(CFG_CLOSE_DIR, 23'd0);
                end
                default: begin
                    write_reg(CFG_MAX_STEPS, 23'($urandom_range(1, 40)));
                    write_reg(CFG_CLOSE_DIR, 23'($urandom_range(0, 1)));
                end
            endcase
            s_gappy = (ph != 2) && ($urandom_range(0, 3) != 0);
            m_gappy = (ph != 2) && ($urandom_range(0, 3) != 0);
            count = 0;
            while (count < PHASE_ITEMS) queue_episode(count);
            wait_drained();
        end

        repeat (8) @(negedge aclk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/csh_pkg.sv
rtl/core/curtain_stepper_homing_fsm.sv
rtl/core/csh_checker.sv
dv/testbench.sv
